// ----- hdl/dlbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlbs_pkg
// Shared types and constants of the dual LED blink sequencer.
// ----------------------------------------------------------------------------
package dlbs_pkg;

  localparam int unsigned CountW = 8;
  localparam int unsigned TicksW = 12;
  localparam int unsigned NumCh  = 2;

  localparam logic [TicksW-1:0] FOREVER_TICKS = 12'hFFF;
  localparam logic [CountW-1:0] FOREVER_COUNT = 8'hFF;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef struct packed {
    logic [CountW-1:0] pending_count;
    logic [TicksW-1:0] reload_on;
    logic [TicksW-1:0] reload_off;
    logic [CountW-1:0] active_count;
    logic [TicksW-1:0] on_left;
    logic [TicksW-1:0] off_left;
    logic              pin_level;
  } chan_state_t;

  typedef struct packed {
    logic is_tick;
    logic req_hit;
    logic [CountW-1:0] repeat_count;
    logic [TicksW-1:0] on_ticks;
    logic [TicksW-1:0] off_ticks;
  } chan_cmd_t;

  typedef struct packed {
    logic pin_level;
    logic busy;
    logic fault;
  } chan_status_t;

endpackage

// ----- hdl/dlbs_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlbs_in_if / dlbs_out_if
// Valid/ready channels for requests and ticks in, pin status out.
// ----------------------------------------------------------------------------
interface dlbs_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic        channel;
  logic [7:0]  repeat_count;
  logic [11:0] on_ticks;
  logic [11:0] off_ticks;

  modport source (output valid, operation, channel, repeat_count, on_ticks, off_ticks,
                  input ready);
  modport sink (input valid, operation, channel, repeat_count, on_ticks, off_ticks,
                output ready);
endinterface

interface dlbs_out_if;
  logic       valid;
  logic       ready;
  logic       led0_level;
  logic       led1_level;
  logic [1:0] busy_mask;
  logic [1:0] fault_mask;

  modport source (output valid, led0_level, led1_level, busy_mask, fault_mask,
                  input ready);
  modport sink (input valid, led0_level, led1_level, busy_mask, fault_mask,
                output ready);
endinterface

// ----- hdl/dual_led_blink_sequencer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_led_blink_sequencer_core
// Two-channel LED blink sequencer with a registered status output.
// The result of an item is presented in the cycle after its transfer. One
// item per cycle is taken while the output is not stalled; the output register
// refills in the cycle it is emptied. Reset idles both channels, both pins high.
// ----------------------------------------------------------------------------
module dual_led_blink_sequencer_core (
  input  logic       clk,
  input  logic       rst_n,
  dlbs_in_if.sink    in_if,
  dlbs_out_if.source out_if
);
  import dlbs_pkg::*;

  logic         accept;
  logic         out_valid_r;
  logic         led0_r;
  logic         led1_r;
  logic [1:0]   busy_r;
  logic [1:0]   fault_r;
  chan_cmd_t    cmd0;
  chan_cmd_t    cmd1;
  chan_status_t stat0;
  chan_status_t stat1;
  logic         req_ok;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign req_ok      = (in_if.operation == OP_REQUEST) && (in_if.repeat_count != '0);

  always_comb begin
    cmd0.is_tick      = (in_if.operation == OP_TICK);
    cmd0.req_hit      = req_ok && (in_if.channel == 1'b0);
    cmd0.repeat_count = in_if.repeat_count;
    cmd0.on_ticks     = in_if.on_ticks;
    cmd0.off_ticks    = in_if.off_ticks;
    cmd1              = cmd0;
    cmd1.req_hit      = req_ok && (in_if.channel == 1'b1);
  end

  dlbs_channel u_ch0 (.clk(clk), .rst_n(rst_n), .accept(accept), .cmd(cmd0), .status(stat0));
  dlbs_channel u_ch1 (.clk(clk), .rst_n(rst_n), .accept(accept), .cmd(cmd1), .status(stat1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      led0_r  <= stat0.pin_level;
      led1_r  <= stat1.pin_level;
      busy_r  <= {stat1.busy, stat0.busy};
      fault_r <= {stat1.fault, stat0.fault};
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.led0_level = led0_r;
  assign out_if.led1_level = led1_r;
  assign out_if.busy_mask  = busy_r;
  assign out_if.fault_mask = fault_r;

endmodule

// ----- hdl/dlbs_channel.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlbs_channel
// State, request load and one-tick step of a single blink channel.
// ----------------------------------------------------------------------------
module dlbs_channel (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  dlbs_pkg::chan_cmd_t   cmd,
  output dlbs_pkg::chan_status_t status
);
  import dlbs_pkg::*;

  chan_state_t st_r;
  chan_state_t st_nxt;
  logic        fault;
  logic [TicksW-1:0] cnt_dec;
  logic [CountW-1:0] act_dec;
  logic              again;

  always_comb begin
    st_nxt  = st_r;
    fault   = 1'b0;
    cnt_dec = '0;
    act_dec = '0;
    again   = 1'b0;
    if (cmd.is_tick) begin
      if (st_nxt.pending_count != '0) begin
        st_nxt.active_count  = st_nxt.pending_count;
        st_nxt.on_left       = st_nxt.reload_on;
        st_nxt.off_left      = st_nxt.reload_off;
        st_nxt.pending_count = '0;
      end
      if (st_nxt.active_count != '0) begin
        if (st_nxt.on_left != '0) begin
          cnt_dec = (st_nxt.on_left == FOREVER_TICKS) ? st_nxt.on_left
                                                      : st_nxt.on_left - 1'b1;
          st_nxt.on_left   = cnt_dec;
          st_nxt.pin_level = (cnt_dec == '0) ? 1'b1 : ~st_nxt.pin_level;
          st_nxt.off_left  = st_nxt.reload_off;
        end else if (st_nxt.off_left != '0) begin
          cnt_dec = (st_nxt.off_left == FOREVER_TICKS) ? st_nxt.off_left
                                                       : st_nxt.off_left - 1'b1;
          st_nxt.off_left = cnt_dec;
          if (cnt_dec == '0) begin
            act_dec = (st_nxt.active_count == FOREVER_COUNT) ? st_nxt.active_count
                                                             : st_nxt.active_count - 1'b1;
            again = (act_dec != '0);
            if (again) begin
              st_nxt.active_count = act_dec;
              st_nxt.pin_level    = ~st_nxt.pin_level;
              st_nxt.on_left      = st_nxt.reload_on;
              st_nxt.off_left     = st_nxt.reload_off;
            end else begin
              st_nxt.pin_level    = 1'b1;
              st_nxt.active_count = '0;
              st_nxt.on_left      = '0;
              st_nxt.off_left     = '0;
            end
          end
        end else begin
          st_nxt.pin_level    = 1'b1;
          st_nxt.active_count = '0;
          st_nxt.on_left      = '0;
          st_nxt.off_left     = '0;
          fault               = 1'b1;
        end
      end
    end else if (cmd.req_hit) begin
      st_nxt.pending_count = cmd.repeat_count;
      st_nxt.reload_on     = cmd.on_ticks;
      st_nxt.reload_off    = cmd.off_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{pin_level: 1'b1, default: '0};
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  assign status.pin_level = st_nxt.pin_level;
  assign status.busy      = (st_nxt.active_count != '0);
  assign status.fault     = fault;

endmodule

// ----- test/tb_dual_led_blink_sequencer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_led_blink_sequencer_core
// Self-checking testbench for the dual LED blink sequencer. Ticks and blink
// requests are driven through the input channel. A behavioral model of both
// channels predicts the pin levels and the busy and fault masks of each
// transfer. Every status transfer is compared field by field with the oldest
// prediction. Directed cases, random patterns, output back-pressure and a
// run with no idle cycles are covered.
// ----------------------------------------------------------------------------
module tb_dual_led_blink_sequencer_core;
  import dlbs_pkg::*;

  typedef struct packed {
    logic       led0_level;
    logic       led1_level;
    logic [1:0] busy_mask;
    logic [1:0] fault_mask;
  } pin_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dlbs_in_if  in_ch ();
  dlbs_out_if out_ch ();

  dual_led_blink_sequencer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #4 clk = ~clk;

  chan_state_t led_chan [NumCh];
  pin_status_t pending_status [$];

  int n_errors = 0;
  int n_sent = 0;
  int n_ticks = 0;
  int n_requests = 0;
  int n_checked = 0;
  int n_fault_ticks = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_off_cycles = 0;

  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) begin
      return 0;
    end
    if ($urandom_range(9) == 0) begin
      return $urandom_range(40, 12);
    end
    return $urandom_range(3, 1);
  endfunction

  function automatic chan_state_t idle_channel(input chan_state_t s);
    chan_state_t n;
    n = s;
    n.pin_level = 1'b1;
    n.active_count = '0;
    n.on_left = '0;
    n.off_left = '0;
    return n;
  endfunction

  function automatic chan_state_t tick_channel(input chan_state_t s, output logic fault);
    chan_state_t n;
    logic again;
    n = s;
    fault = 1'b0;
    again = 1'b0;
    if (n.pending_count != '0) begin
      n.active_count = n.pending_count;
      n.on_left = n.reload_on;
      n.off_left = n.reload_off;
      n.pending_count = '0;
    end
    if (n.active_count != '0) begin
      if (n.on_left != '0) begin
        if (n.on_left != FOREVER_TICKS) begin
          n.on_left = n.on_left - 1'b1;
        end
        n.pin_level = (n.on_left == '0) ? 1'b1 : ~n.pin_level;
        n.off_left = n.reload_off;
      end else if (n.off_left != '0) begin
        if (n.off_left != FOREVER_TICKS) begin
          n.off_left = n.off_left - 1'b1;
        end
        if (n.off_left == '0) begin
          if (n.active_count == FOREVER_COUNT) begin
            again = 1'b1;
          end else begin
            n.active_count = n.active_count - 1'b1;
            again = (n.active_count != '0);
          end
          if (again) begin
            n.pin_level = ~n.pin_level;
            n.on_left = n.reload_on;
            n.off_left = n.reload_off;
          end else begin
            n = idle_channel(n);
          end
        end
      end else begin
        n = idle_channel(n);
        fault = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic pin_status_t predict_status(input logic op, input logic ch,
                                                 input logic [CountW-1:0] cnt,
                                                 input logic [TicksW-1:0] on_t,
                                                 input logic [TicksW-1:0] off_t);
    pin_status_t st;
    logic f0;
    logic f1;
    f0 = 1'b0;
    f1 = 1'b0;
    if (op == OP_REQUEST) begin
      if (cnt != '0) begin
        led_chan[ch].pending_count = cnt;
        led_chan[ch].reload_on = on_t;
        led_chan[ch].reload_off = off_t;
      end
    end else begin
      led_chan[0] = tick_channel(led_chan[0], f0);
      led_chan[1] = tick_channel(led_chan[1], f1);
    end
    st.led0_level = led_chan[0].pin_level;
    st.led1_level = led_chan[1].pin_level;
    st.busy_mask = {led_chan[1].active_count != '0, led_chan[0].active_count != '0};
    st.fault_mask = {f1, f0};
    return st;
  endfunction

  task automatic send_item(input logic op, input logic ch, input logic [CountW-1:0] cnt,
                           input logic [TicksW-1:0] on_t, input logic [TicksW-1:0] off_t);
    int gap;
    pin_status_t st;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.operation = op;
    in_ch.channel = ch;
    in_ch.repeat_count = cnt;
    in_ch.on_ticks = on_t;
    in_ch.off_ticks = off_t;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    st = predict_status(op, ch, cnt, on_t, off_t);
    pending_status.push_back(st);
    n_sent++;
    if (op == OP_TICK) begin
      n_ticks++;
    end else begin
      n_requests++;
    end
    gap = pick_gap(tx_idle_pct);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 1'($urandom), 8'($urandom), 12'($urandom), 12'($urandom));
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_tick();
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_status.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic report_mismatch(input string field, input int exp_val, input int got_val);
    $display("[%0t] status mismatch on %s: expected %0d, got %0d", $realtime, field,
             exp_val, got_val);
    n_errors++;
  endtask

  task automatic check_status();
    pin_status_t exp_st;
    if (pending_status.size() == 0) begin
      $display("[%0t] status transfer with no prediction pending", $realtime);
      n_errors++;
      return;
    end
    exp_st = pending_status.pop_front();
    n_checked++;
    if (out_ch.fault_mask != 2'b00) begin
      n_fault_ticks++;
    end
    if (out_ch.led0_level !== exp_st.led0_level) begin
      report_mismatch("led0_level", exp_st.led0_level, out_ch.led0_level);
    end
    if (out_ch.led1_level !== exp_st.led1_level) begin
      report_mismatch("led1_level", exp_st.led1_level, out_ch.led1_level);
    end
    if (out_ch.busy_mask !== exp_st.busy_mask) begin
      report_mismatch("busy_mask", exp_st.busy_mask, out_ch.busy_mask);
    end
    if (out_ch.fault_mask !== exp_st.fault_mask) begin
      report_mismatch("fault_mask", exp_st.fault_mask, out_ch.fault_mask);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      check_status();
    end
  end

  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ch.ready = 1'b0;
        hold_off_cycles--;
      end else if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        out_ch.ready = 1'b1;
        stall = pick_gap(rx_idle_pct);
      end
    end
  end

  task automatic test_directed();
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    send_tick();
    send_item(OP_REQUEST, 1'b0, 8'd0, 12'd5, 12'd5);
    send_tick();
    send_item(OP_REQUEST, 1'b0, 8'd1, 12'd0, 12'd0);
    send_tick();
    send_item(OP_REQUEST, 1'b1, FOREVER_COUNT, FOREVER_TICKS, FOREVER_TICKS);
    send_ticks(2);
    send_item(OP_REQUEST, 1'b0, 8'd2, 12'd1, 12'd1);
    send_ticks(5);
    send_item(OP_REQUEST, 1'b1, 8'd1, 12'd0, 12'd2);
    send_ticks(3);
    send_item(OP_REQUEST, 1'b0, FOREVER_COUNT, 12'd0, FOREVER_TICKS);
    send_ticks(2);
    send_item(OP_REQUEST, 1'b1, 8'hFE, 12'hFFE, 12'd0);
    send_tick();
    send_item(OP_REQUEST, 1'b0, 8'd1, 12'd0, 12'd0);
    send_item(OP_REQUEST, 1'b1, 8'd1, 12'd0, 12'd0);
    send_tick();
    wait_drained();
  endtask

  function automatic logic [TicksW-1:0] pick_ticks();
    int r;
    r = $urandom_range(99);
    if (r < 85) begin
      return TicksW'($urandom_range(5));
    end
    if (r < 92) begin
      return FOREVER_TICKS;
    end
    return TicksW'($urandom);
  endfunction

  function automatic logic [CountW-1:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 85) begin
      return CountW'($urandom_range(3, 1));
    end
    if (r < 92) begin
      return FOREVER_COUNT;
    end
    return CountW'($urandom);
  endfunction

  task automatic test_random_patterns(input int target);
    int r;
    int n;
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    while (n_sent < target) begin
      r = $urandom_range(99);
      if (r < 70) begin
        send_item(OP_REQUEST, 1'($urandom), pick_count(), pick_ticks(), pick_ticks());
        n = $urandom_range(15);
        repeat (n) begin
          if ($urandom_range(9) == 0) begin
            send_item(OP_REQUEST, 1'($urandom), pick_count(), pick_ticks(), pick_ticks());
          end else begin
            send_tick();
          end
        end
      end else if (r < 85) begin
        send_item(OP_REQUEST, 1'($urandom), 8'($urandom), 12'($urandom), 12'($urandom));
      end else begin
        send_ticks($urandom_range(30, 1));
      end
      if ($urandom_range(19) == 0) begin
        tx_idle_pct = $urandom_range(1) ? 0 : 40;
        rx_idle_pct = $urandom_range(1) ? 0 : 40;
      end
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_off_cycles = 80;
    repeat (30) begin
      if ($urandom_range(3) == 0) begin
        send_item(OP_REQUEST, 1'($urandom), pick_count(), pick_ticks(), pick_ticks());
      end else begin
        send_tick();
      end
    end
    wait_drained();
    send_item(OP_REQUEST, 1'b0, 8'd3, 12'd2, 12'd1);
    wait_drained();
    send_ticks(10);
    wait_drained();
  endtask

  task automatic test_no_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_item(OP_REQUEST, 1'b0, 8'd2, 12'd3, 12'd2);
    send_item(OP_REQUEST, 1'b1, 8'd3, 12'd1, 12'd3);
    repeat (48) begin
      if ($urandom_range(7) == 0) begin
        send_item(OP_REQUEST, 1'($urandom), pick_count(), pick_ticks(), pick_ticks());
      end else begin
        send_tick();
      end
    end
    wait_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_TICK;
    in_ch.channel = 1'b0;
    in_ch.repeat_count = '0;
    in_ch.on_ticks = '0;
    in_ch.off_ticks = '0;
    for (int c = 0; c < NumCh; c++) begin
      led_chan[c] = '0;
      led_chan[c].pin_level = 1'b1;
    end
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_patterns(620);
    test_backpressure();
    test_no_idle();

    @(negedge clk);
    in_ch.valid = 1'b0;
    wait_drained();
    repeat (5) @(posedge clk);

    $display("Sent %0d transfers (%0d ticks, %0d blink requests), checked %0d status results.",
             n_sent, n_ticks, n_requests, n_checked);
    $display("Saw %0d fault ticks; %0d predictions left unmatched.", n_fault_ticks,
             pending_status.size());
    if (n_errors == 0 && pending_status.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: simulation did not finish in time.");
    $display("Test completed with failures");
    $finish;
  end

endmodule
